// File: hw/rtl/iorrb_pkg.sv
// Shared types and constants for the in-order reply reorder buffer.
// No dependencies; imported by iorrb_ctrl, iorrb_dp and the top level.
`timescale 1ns / 1ps

package iorrb_pkg;

    localparam int IDX_W    = 32;
    localparam int KIND_W   = 3;
    localparam int S_DATA_W = 40;   // reply_index + reply_result, padded to bytes
    localparam int M_DATA_W = 40;   // out_index + out_result, padded to bytes

    localparam logic [KIND_W-1:0] KIND_RELEASED  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_STORED    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STALE     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DUPLICATE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BEYOND    = 3'd4;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;  // latch the incoming word
        logic eval;     // classify latched word, update state, load output
        logic drain;    // release the buffered entry at head, load output
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic in_order; // latched word matches next_expected
        logic more;     // slot after head holds a buffered entry
    } dp_status_t;

endpackage

// File: hw/rtl/iorrb_ctrl.sv
// Controller FSM: accepts one word at a time, sequences evaluate and drain steps.
// Depends on iorrb_pkg; drives iorrb_dp through command/status structs.
`timescale 1ns / 1ps

module iorrb_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output iorrb_pkg::dp_cmd_t    cmd,
    input  iorrb_pkg::dp_status_t status
);
    import iorrb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.capture    = 1'b0;
        cmd.eval       = 1'b0;
        cmd.drain      = 1'b0;
        state_next     = state_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (out_free)
                begin
                    cmd.eval       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = (status.in_order && status.more) ? ST_DRAIN : ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    cmd.drain      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = status.more ? ST_DRAIN : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hw/rtl/iorrb_dp.sv
// Datapath: sequence tracking, slot window, result memory and output word register.
// Depends on iorrb_pkg; commanded by iorrb_ctrl.
`timescale 1ns / 1ps

module iorrb_dp
#(
    parameter int DEPTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  iorrb_pkg::dp_cmd_t             cmd,
    output iorrb_pkg::dp_status_t          status,
    input  logic [iorrb_pkg::IDX_W-1:0]    in_index,
    input  logic                           in_result,
    output logic [iorrb_pkg::KIND_W-1:0]   kind,
    output logic [iorrb_pkg::IDX_W-1:0]    out_index,
    output logic                           out_result,
    output logic                           last
);
    import iorrb_pkg::*;

    localparam int              PTR_W     = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    // latched input word
    logic [IDX_W-1:0]  in_index_reg;
    logic              in_result_reg;

    // window state
    logic [IDX_W-1:0]  next_expected_reg;
    logic [PTR_W-1:0]  head_reg;
    logic [DEPTH-1:0]  slot_valid_reg;
    logic [DEPTH-1:0]  slot_valid_next;
    logic              slot_mem [DEPTH];
    logic              rd_reg;

    // output word
    logic [KIND_W-1:0] kind_reg;
    logic [IDX_W-1:0]  out_index_reg;
    logic              out_result_reg;
    logic              last_reg;

    logic [IDX_W-1:0]  delta;
    logic              is_zero;
    logic              in_win;
    logic [PTR_W:0]    pos_sum;
    logic [PTR_W-1:0]  pos;
    logic              dup;
    logic              do_store;
    logic              advance;
    logic [PTR_W-1:0]  head_inc;
    logic [PTR_W-1:0]  head_nxt;
    logic              more;
    logic [KIND_W-1:0] eval_kind;

    assign delta   = in_index_reg - next_expected_reg;
    assign is_zero = (delta == '0);
    assign in_win  = (delta < IDX_W'(DEPTH));

    // (head + d) mod DEPTH, d < DEPTH so one conditional subtract
    assign pos_sum = {1'b0, head_reg} + {1'b0, delta[PTR_W-1:0]};
    assign pos     = (pos_sum >= (PTR_W+1)'(DEPTH)) ? PTR_W'(pos_sum - (PTR_W+1)'(DEPTH))
                                                    : pos_sum[PTR_W-1:0];
    assign dup     = slot_valid_reg[pos];

    assign do_store = cmd.eval && in_win && !is_zero && !dup;
    assign advance  = (cmd.eval && is_zero) || cmd.drain;
    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign head_nxt = advance ? head_inc : head_reg;
    assign more     = slot_valid_reg[head_inc];

    assign status.in_order = is_zero;
    assign status.more     = more;

    always_comb
    begin
        if (is_zero)
            eval_kind = KIND_RELEASED;
        else if (in_win)
            eval_kind = dup ? KIND_DUPLICATE : KIND_STORED;
        else if (delta[IDX_W-1])
            eval_kind = KIND_STALE;
        else
            eval_kind = KIND_BEYOND;
    end

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        if (do_store)
            slot_valid_next[pos] = 1'b1;
        if (cmd.drain)
            slot_valid_next[head_reg] = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_expected_reg <= '0;
            head_reg          <= '0;
            slot_valid_reg    <= '0;
        end
        else
        begin
            if (advance)
                next_expected_reg <= next_expected_reg + 1'b1;
            head_reg       <= head_nxt;
            slot_valid_reg <= slot_valid_next;
        end
    end

    // result memory; read data tracks the slot at head
    always_ff @(posedge clk)
    begin
        if (do_store)
            slot_mem[pos] <= in_result_reg;
        rd_reg <= slot_mem[head_nxt];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_index_reg  <= in_index;
            in_result_reg <= in_result;
        end
        if (cmd.eval)
        begin
            kind_reg       <= eval_kind;
            out_index_reg  <= in_index_reg;
            out_result_reg <= is_zero ? in_result_reg : 1'b0;
            last_reg       <= is_zero ? !more : 1'b1;
        end
        else if (cmd.drain)
        begin
            kind_reg       <= KIND_RELEASED;
            out_index_reg  <= next_expected_reg;
            out_result_reg <= rd_reg;
            last_reg       <= !more;
        end
    end

    assign kind       = kind_reg;
    assign out_index  = out_index_reg;
    assign out_result = out_result_reg;
    assign last       = last_reg;

endmodule

// File: hw/rtl/in_order_reply_reorder_buffer_top.sv
// The first result word is registered in the EVAL state after the input word is
// latched in IDLE; a busy output holds EVAL. One input word is taken at a time: no
// new word is accepted until it is evaluated and any buffered run is drained.
// Reset (rst_n, async, active low) clears next_expected, head and all slot valid
// bits at once; no clearing pass, the block accepts words right after reset.
`timescale 1ns / 1ps

// Top level: in-order reply reorder buffer.
// Depends on iorrb_pkg, iorrb_ctrl and iorrb_dp.
module in_order_reply_reorder_buffer_top
#(
    parameter int DEPTH = 16    // reorder window in slots, 2..64
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // input replies
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [iorrb_pkg::S_DATA_W-1:0]   s_axis_tdata,   // [31:0] reply_index, [32] reply_result
    // released / status words
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [iorrb_pkg::M_DATA_W-1:0]   m_axis_tdata,   // [31:0] out_index, [32] out_result
    output logic [iorrb_pkg::KIND_W-1:0]     m_axis_tuser,   // [2:0] kind
    output logic                             m_axis_tlast    // last word caused by an input word
);
    import iorrb_pkg::*;

    dp_cmd_t           cmd;
    dp_status_t        status;
    logic [IDX_W-1:0]  out_index;
    logic              out_result;

    // Controller: IDLE accepts a word, EVAL classifies it, DRAIN walks the
    // contiguous buffered run behind an in-order release, one word per cycle unless the output stalls.
    iorrb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    // Datapath: modular distance to next_expected, slot window, result memory.
    iorrb_dp #(
        .DEPTH (DEPTH)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_index   (s_axis_tdata[IDX_W-1:0]),
        .in_result  (s_axis_tdata[IDX_W]),
        .kind       (m_axis_tuser),
        .out_index  (out_index),
        .out_result (out_result),
        .last       (m_axis_tlast)
    );

    // pack output word, zero fill to byte boundary
    assign m_axis_tdata = {{(M_DATA_W - IDX_W - 1){1'b0}}, out_result, out_index};

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for in_order_reply_reorder_buffer_top: stream in
// replies, predict each released or status word, and compare in order.
// Depends on iorrb_pkg and the RTL under hw/rtl; reads no files.
`timescale 1ns / 1ps

module tb_top;

    import iorrb_pkg::*;

    localparam int          DEPTH      = 16;
    localparam int unsigned CYCLE_CAP  = 1000000;
    localparam int unsigned RANDOM_GOAL = 420;

    // One expected output word
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [31:0]       index;
        logic              result;
        logic              last;
    } reply_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;    // [31:0] reply_index, [32] reply_result
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;         // [31:0] out_index, [32] out_result
    logic [KIND_W-1:0]     m_axis_tuser;         // [2:0] kind
    logic                  m_axis_tlast;

    // Shadow of the reorder window
    logic [31:0]           order_next = '0;
    int unsigned           order_head = 0;
    logic                  slot_held [DEPTH];
    logic                  slot_bit [DEPTH];

    reply_word_t           pending_words [$];
    int unsigned           fail_count = 0;
    int unsigned           cycle_count = 0;
    int unsigned           gap_max = 19;
    int unsigned           stall_max = 19;
    int unsigned           stall_left = 0;

    in_order_reply_reorder_buffer_top #(
        .DEPTH(DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------
    task automatic push_word(input logic [KIND_W-1:0] kind, input logic [31:0] index,
                             input logic result);
        reply_word_t w;
        w.kind   = kind;
        w.index  = index;
        w.result = result;
        w.last   = 1'b0;
        pending_words.push_back(w);
    endtask

    task automatic advance_window();
        order_next = order_next + 32'd1;
        order_head = (order_head + 1) % DEPTH;
    endtask

    // Classify one accepted reply and queue the words it causes
    task automatic predict_reply(input logic [31:0] index, input logic result);
        logic [31:0] delta;
        int unsigned pos;
        int unsigned n;
        delta = index - order_next;
        if (delta == 32'd0)
        begin
            push_word(KIND_RELEASED, index, result);
            advance_window();
            n = 1;
            // drain the contiguous run behind it
            while (n < DEPTH && slot_held[order_head])
            begin
                push_word(KIND_RELEASED, order_next, slot_bit[order_head]);
                slot_held[order_head] = 1'b0;
                advance_window();
                n++;
            end
        end
        else if (delta < DEPTH)
        begin
            pos = (order_head + delta) % DEPTH;
            if (slot_held[pos])
                push_word(KIND_DUPLICATE, index, 1'b0);
            else
            begin
                slot_held[pos] = 1'b1;
                slot_bit[pos]  = result;
                push_word(KIND_STORED, index, 1'b0);
            end
        end
        else if (delta < 32'h8000_0000)
            push_word(KIND_BEYOND, index, 1'b0);
        else
            push_word(KIND_STALE, index, 1'b0);
        pending_words[pending_words.size() - 1].last = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // Sender side; always entered on a rising edge
    // ---------------------------------------------------------------
    task automatic send_reply(input logic [31:0] index, input logic result);
        int unsigned gap;
        s_axis_tdata  <= {7'd0, result, index};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_reply(index, result);
        gap = $urandom_range(0, gap_max);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and hold off until every expected word has come out
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_words.size() != 0);
    endtask

    // ---------------------------------------------------------------
    // Receiver side: random stalls, then check each accepted word
    // ---------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] expected,
                               input logic [31:0] actual);
        if (expected !== actual)
        begin
            $error("%s: expected %0h, got %0h", name, expected, actual);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : rx_side
        reply_word_t w;
        int unsigned stall;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_words.size() == 0)
                begin
                    $error("unexpected word: kind %0d index %0h", m_axis_tuser,
                           m_axis_tdata[31:0]);
                    fail_count++;
                end
                else
                begin
                    w = pending_words.pop_front();
                    check_field("kind", 32'(w.kind), 32'(m_axis_tuser));
                    check_field("out_index", w.index, m_axis_tdata[31:0]);
                    check_field("out_result", 32'(w.result), 32'(m_axis_tdata[32]));
                    check_field("last", 32'(w.last), 32'(m_axis_tlast));
                end
                stall = $urandom_range(0, stall_max);
                if (stall != 0)
                begin
                    m_axis_tready <= 1'b0;
                    stall_left = stall;
                end
            end
            else
            begin
                if (stall_left != 0)
                    stall_left = stall_left - 1;
                if (stall_left == 0)
                    m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Window edges, duplicates, stale and ahead-of-window cases, modular distance
    task automatic test_edge_cases();
        send_reply(32'd0, 1'b1);            // in order from reset
        send_reply(32'd3, 1'b1);            // stored
        send_reply(32'd3, 1'b0);            // duplicate, first copy kept
        send_reply(32'd2, 1'b0);            // stored
        send_reply(32'd16, 1'b1);           // last slot of the window
        send_reply(32'd17, 1'b0);           // one past the window
        send_reply(32'd0, 1'b1);            // just behind
        send_reply(32'h8000_0000, 1'b1);    // farthest ahead
        send_reply(32'h8000_0001, 1'b0);    // half range away counts as behind
        send_reply(32'hFFFF_FFFF, 1'b1);    // behind across the wrap
        send_reply(32'd1, 1'b1);            // releases 1..3
    endtask

    // Fill every slot after the head, then release the whole window in one burst
    task automatic test_full_drain();
        logic [31:0] base;
        int i;
        base = order_next;
        for (i = DEPTH - 1; i >= 1; i--)
            send_reply(base + i, 1'(i));
        send_reply(base, 1'b0);
    endtask

    // Sender pauses with entries stored until all status words are out
    task automatic test_pause_with_stored();
        logic [31:0] base;
        base = order_next;
        send_reply(base + 2, 1'b1);
        send_reply(base + 1, 1'b0);
        hold_until_drained();
        send_reply(base, 1'b1);
    endtask

    // Mostly shuffled runs of consecutive indices, with stale, far-ahead,
    // repeated and fully random words mixed in
    task automatic test_random_traffic(input int unsigned item_goal);
        logic [31:0] burst [DEPTH];
        logic [31:0] swap;
        int unsigned count;
        int unsigned phase;
        int span;
        int j;
        int pick;
        count = 0;
        while (count < item_goal)
        begin
            phase     = count / 50;
            gap_max   = (phase % 3 == 1) ? 0 : 19;
            stall_max = (phase % 4 == 2) ? 0 : 19;
            case ($urandom_range(0, 9))
                7:
                begin
                    send_reply(order_next - $urandom_range(1, 64), 1'($urandom));
                    count++;
                end
                8:
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_reply(order_next + 32'h7FFF_FFFF - $urandom_range(0, 64),
                                   1'($urandom));
                    else
                        send_reply(order_next + DEPTH + $urandom_range(0, 4096),
                                   1'($urandom));
                    count++;
                end
                9:
                begin
                    send_reply($urandom, 1'($urandom));
                    count++;
                end
                default:
                begin
                    span = $urandom_range(1, DEPTH);
                    for (j = 0; j < span; j++)
                        burst[j] = order_next + j;
                    if ($urandom_range(0, 3) != 0)
                        for (j = span - 1; j >= 1; j--)
                        begin
                            pick        = $urandom_range(0, j);
                            swap        = burst[j];
                            burst[j]    = burst[pick];
                            burst[pick] = swap;
                        end
                    for (j = 0; j < span; j++)
                    begin
                        send_reply(burst[j], 1'($urandom));
                        count++;
                        // resend an earlier member: duplicate or stale
                        if ($urandom_range(0, 9) == 0)
                        begin
                            send_reply(burst[$urandom_range(0, j)], 1'($urandom));
                            count++;
                        end
                    end
                end
            endcase
            if ($urandom_range(0, 39) == 0)
                hold_until_drained();
        end
    endtask

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_held[i] = 1'b0;
            slot_bit[i]  = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_edge_cases();
        test_full_drain();
        test_pause_with_stored();
        test_random_traffic(RANDOM_GOAL);

        hold_until_drained();
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: in_order_reply_reorder_buffer_top.f
hw/rtl/iorrb_pkg.sv
hw/rtl/iorrb_ctrl.sv
hw/rtl/iorrb_dp.sv
hw/rtl/in_order_reply_reorder_buffer_top.sv
verif/tb_top.sv
